@@ sv/usb_device_control_endpoint_assert.svh @@
// Assertion macros shared by the control endpoint RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef USB_DEVICE_CONTROL_ENDPOINT_ASSERT_SVH
`define USB_DEVICE_CONTROL_ENDPOINT_ASSERT_SVH

// same-cycle implication
`define UDCE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("udce: check failed");

// next-cycle implication
`define UDCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("udce: check failed");

`endif

@@ sv/udce_pkg.sv @@
// Package for the USB control endpoint: field widths, codes, table entry types.
// No dependencies.
package udce_pkg;

   localparam int ENDPOINTS_DEFAULT   = 4;
   localparam int DESCRIPTORS_DEFAULT = 8;
   localparam int PACKET_BYTES        = 8;
   localparam int PACKET_SHIFT        = 3;

   localparam int KIND_W    = 3;
   localparam int EP_W      = 2;
   localparam int PAYLOAD_W = 64;
   localparam int SLOT_W    = 3;
   localparam int RESP_W    = 3;
   localparam int PID_W     = 8;
   localparam int ADDR_W    = 16;
   localparam int LEN_W     = 4;
   localparam int DEV_W     = 7;
   localparam int CHUNK_W   = 13;
   localparam int KEY_W     = 32;

   localparam logic [CHUNK_W-1:0] CHUNK_MAX = 13'd8191;

   localparam logic [KIND_W-1:0] KIND_SETUP = 3'd0;
   localparam logic [KIND_W-1:0] KIND_OUT   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_IN    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DATA  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ACK   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd5;

   localparam logic [RESP_W-1:0] RESP_NONE  = 3'd0;
   localparam logic [RESP_W-1:0] RESP_ACK   = 3'd1;
   localparam logic [RESP_W-1:0] RESP_DATA  = 3'd2;
   localparam logic [RESP_W-1:0] RESP_EMPTY = 3'd3;
   localparam logic [RESP_W-1:0] RESP_USER  = 3'd4;

   localparam logic [PID_W-1:0] PID_DATA1 = 8'b0100_1011;
   localparam logic [PID_W-1:0] PID_DATA0 = 8'b1100_0011;
   localparam logic [PID_W-1:0] PID_ACK   = 8'hD2;

   localparam logic [15:0] REQ_DESC_FETCH  = 16'h0680;
   localparam logic [15:0] REQ_SET_ADDRESS = 16'h0500;

   typedef struct packed {
      logic               tog_in;
      logic               tog_out;
      logic [CHUNK_W-1:0] chunk;
      logic [15:0]        length;
      logic [ADDR_W-1:0]  base;
   } ep_entry_type;

   // layout matches the load word: length 63:48, base 47:32, key 31:0
   typedef struct packed {
      logic [15:0]       length;
      logic [ADDR_W-1:0] base;
      logic [KEY_W-1:0]  key;
   } desc_entry_type;

endpackage

@@ sv/udce_req_if.sv @@
// Input channel of the control endpoint: one decoded bus event per word.
// Depends on udce_pkg.
interface udce_req_if;
   import udce_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [EP_W-1:0]      endpoint;
   logic                 data_pid;
   logic [PAYLOAD_W-1:0] payload;
   logic [SLOT_W-1:0]    table_slot;

   modport source (output valid, kind, endpoint, data_pid, payload, table_slot,
                   input ready);
   modport sink   (input valid, kind, endpoint, data_pid, payload, table_slot,
                   output ready);
endinterface

@@ sv/udce_rsp_if.sv @@
// Result channel of the control endpoint: one response word per event.
// Depends on udce_pkg.
interface udce_rsp_if;
   import udce_pkg::*;

   logic              valid;
   logic              ready;
   logic [RESP_W-1:0] response;
   logic [PID_W-1:0]  pid_byte;
   logic [ADDR_W-1:0] source_address;
   logic [LEN_W-1:0]  send_length;
   logic [DEV_W-1:0]  device_address;

   modport source (output valid, response, pid_byte, source_address, send_length,
                   device_address, input ready);
   modport sink   (input valid, response, pid_byte, source_address, send_length,
                   device_address, output ready);
endinterface

@@ sv/udce_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module udce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ sv/usb_device_control_endpoint.sv @@
// An accepted word goes IDLE -> EMIT (OUT, load, ignored kinds) or IDLE -> EXEC -> EMIT
// (SETUP, IN, DATA, ACK); a descriptor-request data stage runs EXEC -> SCAN -> LAST -> EMIT.
// The result is registered when EMIT finds the output free; words are accepted only in IDLE,
// behind the read-modify-write of the endpoint memory and the one-entry-per-cycle descriptor table scan.
// Reset clears control state and the per-entry valid bits; unwritten memory entries
// read as zero, so no clearing pass is needed.
`include "usb_device_control_endpoint_assert.svh"

module usb_device_control_endpoint #(
   parameter int ENDPOINTS   = udce_pkg::ENDPOINTS_DEFAULT,
   parameter int DESCRIPTORS = udce_pkg::DESCRIPTORS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   udce_req_if.sink    req_bus,
   udce_rsp_if.source  rsp_bus
);
   import udce_pkg::*;

   localparam int EP_AW = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;
   localparam int DS_AW = (DESCRIPTORS > 1) ? $clog2(DESCRIPTORS) : 1;
   localparam int EP_DW = $bits(ep_entry_type);
   localparam int DS_DW = $bits(desc_entry_type);

   typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_SCAN, ST_LAST, ST_EMIT} state_type;

   // control state
   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [EP_AW-1:0]     active_ff, active_in;
   logic                 pending_ff, pending_in;
   logic [DEV_W-1:0]     dev_addr_ff, dev_addr_in;
   logic [ENDPOINTS-1:0] ep_valid_ff, ep_valid_in;
   logic [DESCRIPTORS-1:0] ds_valid_ff, ds_valid_in;

   // item and working registers
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [EP_AW-1:0]     ep_ff, ep_in;
   logic                 dpid_ff, dpid_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;
   logic                 tin_ff, tin_in;
   logic                 tout_ff, tout_in;
   logic [ADDR_W-1:0]    fbase_ff, fbase_in;
   logic [15:0]          flen_ff, flen_in;
   logic [DS_AW-1:0]     scan_ff, scan_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [DS_AW-1:0]     rd_idx_ff, rd_idx_in;
   logic [RESP_W-1:0]    res_resp_ff, res_resp_in;
   logic [PID_W-1:0]     res_pid_ff, res_pid_in;
   logic [ADDR_W-1:0]    res_addr_ff, res_addr_in;
   logic [LEN_W-1:0]     res_len_ff, res_len_in;

   // output word
   logic [RESP_W-1:0]    out_resp_ff, out_resp_in;
   logic [PID_W-1:0]     out_pid_ff, out_pid_in;
   logic [ADDR_W-1:0]    out_addr_ff, out_addr_in;
   logic [LEN_W-1:0]     out_len_ff, out_len_in;
   logic [DEV_W-1:0]     out_dev_ff, out_dev_in;

   // memory ports
   logic                 ep_we;
   logic [EP_AW-1:0]     ep_raddr;
   ep_entry_type         ep_wdata;
   logic [EP_DW-1:0]     ep_rdata;
   logic                 ds_we;
   logic [DS_DW-1:0]     ds_rdata;

   logic                 req_fire;
   logic                 out_free;
   logic                 ep_ok;
   logic                 slot_ok;
   logic [EP_AW-1:0]     ep_idx;
   ep_entry_type         ep_ent;
   desc_entry_type       ds_ent;
   desc_entry_type       ds_final;
   logic                 hit;
   logic                 is_get_desc;
   logic                 is_set_addr;
   logic [ADDR_W-1:0]    offset;
   logic [15:0]          remain;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign ep_ok         = int'(req_bus.endpoint) < ENDPOINTS;
   assign slot_ok       = int'(req_bus.table_slot) < DESCRIPTORS;
   assign ep_idx        = EP_AW'(req_bus.endpoint);

   // DATA and ACK act on the endpoint of the last token
   assign ep_raddr = (req_bus.kind == KIND_DATA || req_bus.kind == KIND_ACK) ?
                     active_ff : ep_idx;
   assign ep_ent   = ep_valid_ff[ep_ff] ? ep_entry_type'(ep_rdata) : '0;
   assign ds_we    = req_fire && req_bus.kind == KIND_LOAD && slot_ok;
   assign ds_ent   = ds_valid_ff[rd_idx_ff] ? desc_entry_type'(ds_rdata) : '0;
   assign hit      = rd_pend_ff && ds_ent.key == payload_ff[47:16];
   assign ds_final = hit ? ds_ent
                         : desc_entry_type'{length: flen_ff, base: fbase_ff, key: '0};

   assign is_get_desc = payload_ff[15:1] == REQ_DESC_FETCH[15:1];
   assign is_set_addr = payload_ff[15:1] == REQ_SET_ADDRESS[15:1];
   assign offset      = ADDR_W'(ep_ent.chunk) << PACKET_SHIFT;
   assign remain      = ep_ent.length - offset;

   udce_ram #(.WIDTH(EP_DW), .DEPTH(ENDPOINTS)) u_ep_ram (
      .clock (clock),
      .we    (ep_we),
      .waddr (ep_ff),
      .wdata (ep_wdata),
      .raddr (ep_raddr),
      .rdata (ep_rdata)
   );

   udce_ram #(.WIDTH(DS_DW), .DEPTH(DESCRIPTORS)) u_desc_ram (
      .clock (clock),
      .we    (ds_we),
      .waddr (DS_AW'(req_bus.table_slot)),
      .wdata (req_bus.payload),
      .raddr (scan_ff),
      .rdata (ds_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      active_in    = active_ff;
      pending_in   = pending_ff;
      dev_addr_in  = dev_addr_ff;
      ep_valid_in  = ep_valid_ff;
      ds_valid_in  = ds_valid_ff;
      kind_in      = kind_ff;
      ep_in        = ep_ff;
      dpid_in      = dpid_ff;
      payload_in   = payload_ff;
      tin_in       = tin_ff;
      tout_in      = tout_ff;
      fbase_in     = fbase_ff;
      flen_in      = flen_ff;
      scan_in      = scan_ff;
      rd_pend_in   = rd_pend_ff;
      rd_idx_in    = rd_idx_ff;
      res_resp_in  = res_resp_ff;
      res_pid_in   = res_pid_ff;
      res_addr_in  = res_addr_ff;
      res_len_in   = res_len_ff;
      out_resp_in  = out_resp_ff;
      out_pid_in   = out_pid_ff;
      out_addr_in  = out_addr_ff;
      out_len_in   = out_len_ff;
      out_dev_in   = out_dev_ff;
      ep_we        = 1'b0;
      ep_wdata     = ep_ent;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in     = req_bus.kind;
               ep_in       = ep_raddr;
               dpid_in     = req_bus.data_pid;
               payload_in  = req_bus.payload;
               res_resp_in = RESP_NONE;
               res_pid_in  = '0;
               res_addr_in = '0;
               res_len_in  = '0;
               state_in    = ST_EMIT;
               case (req_bus.kind)
                  KIND_SETUP: begin
                     if (ep_ok) begin
                        state_in = ST_EXEC;
                     end
                  end
                  KIND_OUT: begin
                     if (ep_ok) begin
                        active_in = ep_idx;
                     end
                  end
                  KIND_IN: begin
                     if (ep_ok) begin
                        active_in = ep_idx;
                        state_in  = ST_EXEC;
                     end
                  end
                  KIND_DATA, KIND_ACK: begin
                     state_in = ST_EXEC;
                  end
                  KIND_LOAD: begin
                     if (slot_ok) begin
                        ds_valid_in[DS_AW'(req_bus.table_slot)] = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_EXEC: begin
            state_in = ST_EMIT;
            case (kind_ff)
               KIND_SETUP: begin
                  active_in        = ep_ff;
                  pending_in       = 1'b1;
                  ep_wdata.tog_in  = 1'b1;
                  ep_wdata.tog_out = 1'b0;
                  ep_wdata.chunk   = '0;
                  ep_wdata.base    = '0;
                  ep_we            = 1'b1;
               end
               KIND_IN: begin
                  res_pid_in = ep_ent.tog_in ? PID_DATA1 : PID_DATA0;
                  if (ep_ff != '0) begin
                     res_resp_in = RESP_USER;
                  end else if (ep_ent.length <= offset) begin
                     res_resp_in = RESP_EMPTY;
                  end else begin
                     res_resp_in = RESP_DATA;
                     res_addr_in = ep_ent.base + offset;
                     res_len_in  = (remain > 16'(PACKET_BYTES)) ? LEN_W'(PACKET_BYTES)
                                                                : remain[LEN_W-1:0];
                  end
               end
               KIND_ACK: begin
                  ep_wdata.tog_in = !ep_ent.tog_in;
                  if (ep_ent.chunk != CHUNK_MAX) begin
                     ep_wdata.chunk = ep_ent.chunk + CHUNK_W'(1);
                  end
                  ep_we = 1'b1;
               end
               KIND_DATA: begin
                  res_resp_in = RESP_ACK;
                  res_pid_in  = PID_ACK;
                  if (ep_ent.tog_out == dpid_ff) begin
                     ep_wdata.tog_out = !ep_ent.tog_out;
                     ep_we            = 1'b1;
                     if (pending_ff) begin
                        pending_in      = 1'b0;
                        ep_wdata.chunk  = '0;
                        ep_wdata.base   = '0;
                        ep_wdata.length = '0;
                        if (is_get_desc) begin
                           // write back after the table scan
                           ep_we      = 1'b0;
                           tin_in     = ep_ent.tog_in;
                           tout_in    = !ep_ent.tog_out;
                           fbase_in   = '0;
                           flen_in    = '0;
                           scan_in    = '0;
                           rd_pend_in = 1'b0;
                           state_in   = ST_SCAN;
                        end else if (is_set_addr) begin
                           dev_addr_in = payload_ff[16 +: DEV_W];
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         ST_SCAN: begin
            if (hit) begin
               fbase_in = ds_ent.base;
               flen_in  = ds_ent.length;
            end
            rd_pend_in = 1'b1;
            rd_idx_in  = scan_ff;
            scan_in    = scan_ff + DS_AW'(1);
            if (scan_ff == DS_AW'(DESCRIPTORS - 1)) begin
               state_in = ST_LAST;
            end
         end

         ST_LAST: begin
            ep_wdata.tog_in  = tin_ff;
            ep_wdata.tog_out = tout_ff;
            ep_wdata.chunk   = '0;
            ep_wdata.base    = ds_final.base;
            ep_wdata.length  = (payload_ff[63:48] < ds_final.length) ? payload_ff[63:48]
                                                                     : ds_final.length;
            ep_we            = 1'b1;
            state_in         = ST_EMIT;
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_resp_in  = res_resp_ff;
               out_pid_in   = res_pid_ff;
               out_addr_in  = res_addr_ff;
               out_len_in   = res_len_ff;
               out_dev_in   = dev_addr_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (ep_we) begin
         ep_valid_in[ep_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= '0;
         pending_ff   <= 1'b0;
         dev_addr_ff  <= '0;
         ep_valid_ff  <= '0;
         ds_valid_ff  <= '0;
         out_resp_ff  <= '0;
         out_pid_ff   <= '0;
         out_addr_ff  <= '0;
         out_len_ff   <= '0;
         out_dev_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         pending_ff   <= pending_in;
         dev_addr_ff  <= dev_addr_in;
         ep_valid_ff  <= ep_valid_in;
         ds_valid_ff  <= ds_valid_in;
         out_resp_ff  <= out_resp_in;
         out_pid_ff   <= out_pid_in;
         out_addr_ff  <= out_addr_in;
         out_len_ff   <= out_len_in;
         out_dev_ff   <= out_dev_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      ep_ff       <= ep_in;
      dpid_ff     <= dpid_in;
      payload_ff  <= payload_in;
      tin_ff      <= tin_in;
      tout_ff     <= tout_in;
      fbase_ff    <= fbase_in;
      flen_ff     <= flen_in;
      scan_ff     <= scan_in;
      rd_pend_ff  <= rd_pend_in;
      rd_idx_ff   <= rd_idx_in;
      res_resp_ff <= res_resp_in;
      res_pid_ff  <= res_pid_in;
      res_addr_ff <= res_addr_in;
      res_len_ff  <= res_len_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.response       = out_resp_ff;
   assign rsp_bus.pid_byte       = out_pid_ff;
   assign rsp_bus.source_address = out_addr_ff;
   assign rsp_bus.send_length    = out_len_ff;
   assign rsp_bus.device_address = out_dev_ff;

   `UDCE_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_fire, state_ff != ST_IDLE)
   `UDCE_ASSERT_NOW(a_desc_write_on_load, clock, reset, ds_we,
                    req_fire && req_bus.kind == KIND_LOAD)
   `UDCE_ASSERT_NOW(a_ep_write_when_busy, clock, reset, ep_we,
                    state_ff == ST_EXEC || state_ff == ST_LAST)
   `UDCE_ASSERT_NOW(a_none_is_quiet, clock, reset, rsp_valid_ff && out_resp_ff == RESP_NONE,
                    out_pid_ff == '0 && out_len_ff == '0)
   `UDCE_ASSERT_NEXT(a_emit_loads_word, clock, reset, state_ff == ST_EMIT && out_free,
                     rsp_valid_ff && state_ff == ST_IDLE)

endmodule
